/* hdl/ilha_pkg.sv */
// shared types, codes and helpers for the implicit list heap allocator
// used by ilha_mem, implicit_list_heap_allocator and ilha_chk
`default_nettype none
package ilha_pkg;

   localparam int HEAP_BYTES_DEF = 65536;
   localparam int ADDR_W         = 36;
   localparam int WORD_W         = 32;
   localparam int CHUNK_W        = 17;
   localparam int ASIZE_W        = 17;
   localparam int MIN_BLOCK      = 16;
   localparam int LIST_START     = 8;
   localparam int WQ_DEPTH       = 4;
   localparam int CSR_INDEX_W    = 2;

   localparam logic [1:0] MODE_INIT  = 2'd0;
   localparam logic [1:0] MODE_ALLOC = 2'd1;
   localparam logic [1:0] MODE_FREE  = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam logic [1:0] STAT_DONE = 2'd0;
   localparam logic [1:0] STAT_NULL = 2'd1;
   localparam logic [1:0] STAT_OOM  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHUNK = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIT   = 2'd1;

   typedef enum logic [1:0] {CMD_INIT, CMD_ALLOC, CMD_FREE} cmd_type;

   typedef enum logic [4:0] {
      S_IDLE, S_WRITE, S_GROW, S_FF_RD, S_FF_EV, S_FREE_RD, S_FREE_EV,
      S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_PL_RD, S_PL_EV, S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] request_size;
      logic [15:0] block_address;
   } req_type;

   typedef struct packed {
      logic [15:0] result_address;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } wq_entry_type;

   // size field of a boundary tag
   function automatic logic [ADDR_W-1:0] tag_size(input logic [WORD_W-1:0] w);
      return {{(ADDR_W-WORD_W){1'b0}}, w[WORD_W-1:3], 3'b000};
   endfunction

endpackage
`default_nettype wire

/* hdl/ilha_mem.sv */
// heap word memory, one port, registered read, out-of-range reads give zero
// depends on ilha_pkg
`default_nettype none
module ilha_mem
   import ilha_pkg::*;
#(
   parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WORD_W-1:0] wr_data,
   output      logic [WORD_W-1:0] rd_data
);
   localparam int HEAP_WORDS = HEAP_BYTES / 4;
   localparam int IDX_W      = $clog2(HEAP_WORDS);
   localparam logic [ADDR_W-1:0] LIMIT = ADDR_W'(HEAP_WORDS * 4);

   logic [WORD_W-1:0] mem [HEAP_WORDS];
   logic [WORD_W-1:0] q_ff;
   logic              oob_ff;
   logic              in_range;
   logic [IDX_W-1:0]  idx;

   assign in_range = addr < LIMIT;
   assign idx      = addr[IDX_W+1:2];

   always_ff @(posedge clock) begin
      if (wr_en && in_range) begin
         mem[idx] <= wr_data;
      end
      if (rd_en) begin
         q_ff   <= mem[idx];
         oob_ff <= !in_range;
      end
   end

   assign rd_data = oob_ff ? '0 : q_ff;
endmodule
`default_nettype wire

/* hdl/implicit_list_heap_allocator.sv */
// top level of the implicit list heap allocator: sequencer around one heap memory
// depends on ilha_pkg and ilha_mem
//
// One beat in, one beat out. Each beat is worked by a sequencer that owns the
// single port of the heap word memory: a memory read is registered and the
// data is used in the next state, so walking the block list reads and then
// evaluates each block header visited (first fit stops at the first block that
// fits, best fit visits every block up to the break). After the walk, allocate
// reads the tag, writes two tags, or four when it splits, and responds; when the
// heap has to grow it first writes three tags, does five merge reads and up to
// two merge writes. Release reads the header, writes two tags and then merges
// the same way; initialize writes four words and then grows the heap unless it
// cannot grow; a null or ignored request goes straight to the response. Each
// burst of queued writes leaves the write state once its last word is written.
// There is no clearing pass: the heap is undefined until initialize writes it.
// A new request beat is taken in the idle state, also while the previous
// response beat still waits on rsp_ready.
`default_nettype none
module implicit_list_heap_allocator
   import ilha_pkg::*;
#(
   parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire req_type                req_data,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      rsp_type                rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CHUNK_W-1:0]     csr_wdata
);
   localparam logic [ADDR_W-1:0] HEAP_LIMIT = ADDR_W'(HEAP_BYTES);
   localparam logic [ADDR_W-1:0] A4  = ADDR_W'(4);
   localparam logic [ADDR_W-1:0] A8  = ADDR_W'(8);
   localparam logic [ADDR_W-1:0] MIN = ADDR_W'(MIN_BLOCK);

   // sequencer state
   state_type         state_ff, state_in;
   state_type         cont_ff, cont_in;       // where to go after queued writes
   cmd_type           cmd_ff, cmd_in;
   logic [ADDR_W-1:0] brk_ff, brk_in;         // break offset
   logic              ready_heap_ff, ready_heap_in; // list start set
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic              fit_ff, fit_in;

   // working registers
   logic [ADDR_W-1:0] asize_ff, asize_in;
   logic [ADDR_W-1:0] bp_ff, bp_in;
   logic [ADDR_W-1:0] best_ff, best_in;
   logic [WORD_W-1:0] best_sz_ff, best_sz_in;
   logic [ADDR_W-1:0] pv_ff, pv_in;
   logic [ADDR_W-1:0] nx_ff, nx_in;
   logic [ADDR_W-1:0] szbp_ff, szbp_in;
   logic [ADDR_W-1:0] szpv_ff, szpv_in;
   logic [ADDR_W-1:0] szn_ff, szn_in;
   logic              na_ff, na_in;
   logic [15:0]       res_ff, res_in;
   logic [1:0]        stat_ff, stat_in;

   // write queue, drained one word per cycle
   wq_entry_type      wq_ff [WQ_DEPTH];
   wq_entry_type      wq_in [WQ_DEPTH];
   logic [2:0]        wq_n_ff, wq_n_in;
   logic [2:0]        wq_i_ff, wq_i_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // memory port
   logic              mem_re, mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [WORD_W-1:0] mem_wdata, mem_rdata;

   // shared decode
   logic [ADDR_W-1:0] chunk_eff, rd_size, grow_bytes, grow_size;
   logic              accept, grow_fail, walk_end, fit_hit, rsp_free;
   logic              pa, pv_nx_same;
   logic [ADDR_W-1:0] m_size, nx_size_fwd;
   logic [ADDR_W-1:0] req_ext, req_asize;

   ilha_mem #(.HEAP_BYTES(HEAP_BYTES)) u_mem (
      .clock   (clock),
      .rd_en   (mem_re),
      .wr_en   (mem_we),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // chunk rounded down to eight, never zero
   assign chunk_eff = ({chunk_ff[CHUNK_W-1:3], 3'b000} == '0) ? A8 :
                      ADDR_W'({chunk_ff[CHUNK_W-1:3], 3'b000});
   assign rd_size   = tag_size(mem_rdata);
   assign grow_bytes = (cmd_ff == CMD_ALLOC && asize_ff > chunk_eff) ? asize_ff : chunk_eff;
   assign grow_size = (grow_bytes + ADDR_W'(7)) & ~ADDR_W'(7);
   assign grow_fail = (brk_ff + grow_size) > HEAP_LIMIT;
   assign walk_end  = bp_ff >= brk_ff;
   assign fit_hit   = !mem_rdata[0] && (rd_size >= asize_ff);

   assign req_ext   = ADDR_W'(req_data.request_size);
   assign req_asize = (req_ext <= A8) ? MIN :
                      ((req_ext + ADDR_W'(15)) & ~ADDR_W'(7));

   // merge decision, valid in the last merge state
   assign pa = mem_rdata[0];
   always_comb begin
      if (pa) begin
         m_size = szbp_ff + szn_ff;
      end else if (na_ff) begin
         m_size = szbp_ff + szpv_ff;
      end else begin
         m_size = szbp_ff + szpv_ff + szn_ff;
      end
   end
   // the tail write uses the next header size, forwarded when the first write hits that header
   assign pv_nx_same  = ((pv_ff - A4) >> 2) == ((nx_ff - A4) >> 2) &&
                        (pv_ff - A4) < HEAP_LIMIT;
   assign nx_size_fwd = pv_nx_same ? tag_size(m_size[WORD_W-1:0]) : szn_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority if (req_data.mode == MODE_INIT) begin
                  state_in = S_WRITE;
               end else if (req_data.mode == MODE_ALLOC) begin
                  state_in = (req_data.request_size == '0 || !ready_heap_ff) ?
                             S_DONE : S_FF_RD;
               end else if (req_data.mode == MODE_FREE) begin
                  state_in = (req_data.block_address == '0 || !ready_heap_ff) ?
                             S_DONE : S_FREE_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_WRITE:   state_in = (wq_i_ff == wq_n_ff) ? cont_ff : S_WRITE;
         S_GROW:    state_in = grow_fail ? S_DONE : S_WRITE;
         S_FF_RD: begin
            if (walk_end) begin
               state_in = (best_ff != '0) ? S_PL_RD : S_GROW;
            end else begin
               state_in = S_FF_EV;
            end
         end
         S_FF_EV: begin
            if (rd_size == '0) begin
               state_in = (best_ff != '0) ? S_PL_RD : S_GROW;
            end else if (fit_hit && !fit_ff) begin
               state_in = S_PL_RD;
            end else begin
               state_in = S_FF_RD;
            end
         end
         S_FREE_RD: state_in = S_FREE_EV;
         S_FREE_EV: state_in = S_WRITE;
         S_M1:      state_in = S_M2;
         S_M2:      state_in = S_M3;
         S_M3:      state_in = S_M4;
         S_M4:      state_in = S_M5;
         S_M5:      state_in = S_M6;
         S_M6:      state_in = S_WRITE;
         S_PL_RD:   state_in = S_PL_EV;
         S_PL_EV:   state_in = S_WRITE;
         S_DONE:    state_in = rsp_free ? S_IDLE : S_DONE;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      cont_in       = cont_ff;
      cmd_in        = cmd_ff;
      brk_in        = brk_ff;
      ready_heap_in = ready_heap_ff;
      chunk_in      = chunk_ff;
      fit_in        = fit_ff;
      asize_in      = asize_ff;
      bp_in         = bp_ff;
      best_in       = best_ff;
      best_sz_in    = best_sz_ff;
      pv_in         = pv_ff;
      nx_in         = nx_ff;
      szbp_in       = szbp_ff;
      szpv_in       = szpv_ff;
      szn_in        = szn_ff;
      na_in         = na_ff;
      res_in        = res_ff;
      stat_in       = stat_ff;
      wq_in         = wq_ff;
      wq_n_in       = wq_n_ff;
      wq_i_in       = wq_i_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      mem_addr      = bp_ff - A4;
      mem_wdata     = wq_ff[wq_i_ff[1:0]].data;

      if (csr_we) begin
         if (csr_index == CSR_CHUNK) begin
            chunk_in = csr_wdata;
         end else if (csr_index == CSR_FIT) begin
            fit_in = csr_wdata[0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in  = '0;
               stat_in = STAT_DONE;
               wq_i_in = '0;
               priority if (req_data.mode == MODE_INIT) begin
                  // pad, prologue header and footer, epilogue
                  cmd_in        = CMD_INIT;
                  brk_in        = ADDR_W'(16);
                  ready_heap_in = 1'b1;
                  wq_in[0]      = '{addr: ADDR_W'(0),  data: WORD_W'(0)};
                  wq_in[1]      = '{addr: ADDR_W'(4),  data: WORD_W'(9)};
                  wq_in[2]      = '{addr: ADDR_W'(8),  data: WORD_W'(9)};
                  wq_in[3]      = '{addr: ADDR_W'(12), data: WORD_W'(1)};
                  wq_n_in       = 3'd4;
                  cont_in       = S_GROW;
               end else if (req_data.mode == MODE_ALLOC) begin
                  cmd_in     = CMD_ALLOC;
                  asize_in   = req_asize;
                  bp_in      = ADDR_W'(LIST_START);
                  best_in    = '0;
                  best_sz_in = '1;
                  if (req_data.request_size == '0) begin
                     stat_in = STAT_NULL;
                  end else if (!ready_heap_ff) begin
                     stat_in = STAT_OOM;
                  end
               end else if (req_data.mode == MODE_FREE) begin
                  cmd_in = CMD_FREE;
                  bp_in  = ADDR_W'(req_data.block_address);
                  if (req_data.block_address == '0 || !ready_heap_ff) begin
                     stat_in = STAT_NULL;
                  end
               end else begin
                  stat_in = STAT_NULL;
               end
            end
         end
         S_WRITE: begin
            if (wq_i_ff != wq_n_ff) begin
               mem_we    = 1'b1;
               mem_addr  = wq_ff[wq_i_ff[1:0]].addr;
               wq_i_in   = wq_i_ff + 3'd1;
            end
         end
         S_GROW: begin
            wq_i_in = '0;
            if (grow_fail) begin
               stat_in = STAT_OOM;
               res_in  = '0;
            end else begin
               // new free block, its footer and a fresh epilogue
               brk_in   = brk_ff + grow_size;
               bp_in    = brk_ff;
               wq_in[0] = '{addr: brk_ff - A4, data: grow_size[WORD_W-1:0]};
               wq_in[1] = '{addr: brk_ff + grow_size - A8, data: grow_size[WORD_W-1:0]};
               wq_in[2] = '{addr: brk_ff + grow_size - A4, data: WORD_W'(1)};
               wq_n_in  = 3'd3;
               cont_in  = S_M1;
            end
         end
         S_FF_RD: begin
            if (walk_end) begin
               if (best_ff != '0) begin
                  bp_in = best_ff;
               end
            end else begin
               mem_re   = 1'b1;
               mem_addr = bp_ff - A4;
            end
         end
         S_FF_EV: begin
            if (rd_size == '0) begin
               if (best_ff != '0) begin
                  bp_in = best_ff;
               end
            end else if (fit_hit && !fit_ff) begin
               bp_in = bp_ff;
            end else begin
               if (fit_hit && (rd_size < ADDR_W'(best_sz_ff))) begin
                  best_in    = bp_ff;
                  best_sz_in = rd_size[WORD_W-1:0];
               end
               bp_in = bp_ff + rd_size;
            end
         end
         S_FREE_RD: begin
            mem_re   = 1'b1;
            mem_addr = bp_ff - A4;
         end
         S_FREE_EV: begin
            wq_i_in  = '0;
            wq_in[0] = '{addr: bp_ff - A4, data: rd_size[WORD_W-1:0]};
            wq_in[1] = '{addr: bp_ff + rd_size - A8, data: rd_size[WORD_W-1:0]};
            wq_n_in  = 3'd2;
            cont_in  = S_M1;
         end
         S_M1: begin
            mem_re   = 1'b1;
            mem_addr = bp_ff - A8;
         end
         S_M2: begin
            pv_in    = bp_ff - rd_size;
            mem_re   = 1'b1;
            mem_addr = bp_ff - A4;
         end
         S_M3: begin
            szbp_in  = rd_size;
            nx_in    = bp_ff + rd_size;
            mem_re   = 1'b1;
            mem_addr = pv_ff - A4;
         end
         S_M4: begin
            szpv_in  = rd_size;
            mem_re   = 1'b1;
            mem_addr = nx_ff - A4;
         end
         S_M5: begin
            szn_in   = rd_size;
            na_in    = mem_rdata[0];
            mem_re   = 1'b1;
            mem_addr = pv_ff + szpv_ff - A8;
         end
         S_M6: begin
            // four merge cases, then place or finish
            wq_i_in = '0;
            cont_in = (cmd_ff == CMD_ALLOC) ? S_PL_RD : S_DONE;
            if (pa && na_ff) begin
               wq_n_in = '0;
            end else if (pa) begin
               wq_in[0] = '{addr: bp_ff - A4, data: m_size[WORD_W-1:0]};
               wq_in[1] = '{addr: bp_ff + m_size - A8, data: m_size[WORD_W-1:0]};
               wq_n_in  = 3'd2;
            end else if (na_ff) begin
               wq_in[0] = '{addr: bp_ff + szbp_ff - A8, data: m_size[WORD_W-1:0]};
               wq_in[1] = '{addr: pv_ff - A4, data: m_size[WORD_W-1:0]};
               wq_n_in  = 3'd2;
               bp_in    = pv_ff;
            end else begin
               wq_in[0] = '{addr: pv_ff - A4, data: m_size[WORD_W-1:0]};
               wq_in[1] = '{addr: nx_ff + nx_size_fwd - A8, data: m_size[WORD_W-1:0]};
               wq_n_in  = 3'd2;
               bp_in    = pv_ff;
            end
         end
         S_PL_RD: begin
            mem_re   = 1'b1;
            mem_addr = bp_ff - A4;
         end
         S_PL_EV: begin
            wq_i_in = '0;
            cont_in = S_DONE;
            res_in  = bp_ff[15:0];
            stat_in = STAT_DONE;
            if (rd_size >= asize_ff + MIN) begin
               // split off the rest as a free block
               wq_in[0] = '{addr: bp_ff - A4, data: asize_ff[WORD_W-1:0] | WORD_W'(1)};
               wq_in[1] = '{addr: bp_ff + asize_ff - A8,
                            data: asize_ff[WORD_W-1:0] | WORD_W'(1)};
               wq_in[2] = '{addr: bp_ff + asize_ff - A4,
                            data: WORD_W'(rd_size - asize_ff)};
               wq_in[3] = '{addr: bp_ff + rd_size - A8,
                            data: WORD_W'(rd_size - asize_ff)};
               wq_n_in  = 3'd4;
            end else begin
               wq_in[0] = '{addr: bp_ff - A4, data: rd_size[WORD_W-1:0] | WORD_W'(1)};
               wq_in[1] = '{addr: bp_ff + rd_size - A8,
                            data: rd_size[WORD_W-1:0] | WORD_W'(1)};
               wq_n_in  = 3'd2;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{result_address: res_ff, status: stat_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         brk_ff        <= '0;
         ready_heap_ff <= 1'b0;
         chunk_ff      <= CHUNK_W'(4096);
         fit_ff        <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         wq_n_ff       <= '0;
         wq_i_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         brk_ff        <= brk_in;
         ready_heap_ff <= ready_heap_in;
         chunk_ff      <= chunk_in;
         fit_ff        <= fit_in;
         rsp_valid_ff  <= rsp_valid_in;
         wq_n_ff       <= wq_n_in;
         wq_i_ff       <= wq_i_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      cont_ff    <= cont_in;
      cmd_ff     <= cmd_in;
      asize_ff   <= asize_in;
      bp_ff      <= bp_in;
      best_ff    <= best_in;
      best_sz_ff <= best_sz_in;
      pv_ff      <= pv_in;
      nx_ff      <= nx_in;
      szbp_ff    <= szbp_in;
      szpv_ff    <= szpv_in;
      szn_ff     <= szn_in;
      na_ff      <= na_in;
      res_ff     <= res_in;
      stat_ff    <= stat_in;
      wq_ff      <= wq_in;
      rsp_ff     <= rsp_in;
   end
endmodule
`default_nettype wire

/* hdl/ilha_chk.sv */
// port-level checker for the heap allocator and its bind
// depends on ilha_pkg and implicit_list_heap_allocator
`default_nettype none
module ilha_chk
   import ilha_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);
   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // no response right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // only a response with done status carries an address
   a_addr_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STAT_DONE |-> rsp_data.result_address == '0)
      else $error("address on a failed or ignored request");

   // status code stays within its defined values
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status == STAT_DONE || rsp_data.status == STAT_NULL ||
                    rsp_data.status == STAT_OOM)
      else $error("undefined status code");

   // a request taken is not followed by another accept in the next cycle
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");
endmodule

bind implicit_list_heap_allocator ilha_chk u_ilha_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
